FILE: sv/h264_sps_resolution_parser_assert.svh
// Assertion macros for the SPS resolution parser.
`ifndef H264_SPS_RESOLUTION_PARSER_ASSERT_SVH
`define H264_SPS_RESOLUTION_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define SPS_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SPS_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: sv/sps_pkg.sv
`default_nettype none
package sps_pkg;

  localparam int MAX_ZERO_RUN = 31;
  localparam int DIM_BITS = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_HEADER = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic first_byte;
    logic last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] width_pixels;
    logic [15:0] height_pixels;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [4:0] {
    PH_HDR, PH_PROFILE, PH_CONSTR, PH_LEVEL, PH_SPSID, PH_CHROMA, PH_SEPCOL,
    PH_DEPTHL, PH_DEPTHC, PH_BYPASS, PH_MATRIX, PH_LISTFLAG, PH_DELTA,
    PH_LOG2FN, PH_POCTYPE, PH_LOG2POC, PH_ALWAYSZ, PH_NONREF, PH_TOPBOT,
    PH_CYCLE, PH_REFOFF, PH_MAXREF, PH_GAPS, PH_WIDTH, PH_HEIGHT, PH_FMO,
    PH_MBAFF, PH_D8X8, PH_CROPF, PH_CROP, PH_DONE
  } phase_t;

  // Back-end sub-steps while a byte is consumed.
  typedef enum logic [1:0] {BE_IDLE, BE_BITS, BE_SIZE1, BE_SIZE2} be_state_t;

  // Fixed field width in bits; zero means an Exp-Golomb code.
  function automatic logic [3:0] field_bits(input phase_t p);
    case (p)
      PH_PROFILE, PH_CONSTR, PH_LEVEL: field_bits = 4'd8;
      PH_SEPCOL, PH_BYPASS, PH_MATRIX, PH_LISTFLAG, PH_ALWAYSZ, PH_GAPS,
      PH_FMO, PH_MBAFF, PH_D8X8, PH_CROPF: field_bits = 4'd1;
      default: field_bits = 4'd0;
    endcase
  endfunction

  function automatic logic is_high_profile(input logic [7:0] p);
    is_high_profile = (p == 8'd100) || (p == 8'd110) || (p == 8'd122) ||
                      (p == 8'd244) || (p == 8'd44) || (p == 8'd83) ||
                      (p == 8'd86) || (p == 8'd118) || (p == 8'd128) ||
                      (p == 8'd138) || (p == 8'd139) || (p == 8'd134) ||
                      (p == 8'd135);
  endfunction

endpackage
`default_nettype wire

FILE: sv/sps_queue.sv
`default_nettype none
module sps_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire sps_pkg::in_item_t wr_data,
  output logic full,
  input  wire logic rd_en,
  output sps_pkg::in_item_t rd_data,
  output logic empty
);
  import sps_pkg::*;

  in_item_t mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0] count;

  assign full = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en && !full)
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en && !empty)
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (QPTR_BITS+1)'(wr_en && !full) - (QPTR_BITS+1)'(rd_en && !empty);
    end
  end
endmodule
`default_nettype wire

FILE: sv/sps_engine.sv
`default_nettype none
module sps_engine (
  input  wire logic clk,
  input  wire logic rst,
  input  wire sps_pkg::in_item_t q_data,
  input  wire logic q_empty,
  output logic q_pop,
  output sps_pkg::out_item_t res_data,
  output logic res_valid,
  input  wire logic res_pop
);
  import sps_pkg::*;

  be_state_t be, be_next;
  phase_t phase;
  logic [2:0] header_count;
  logic [5:0] zero_run, suffix_left;
  logic in_suffix;
  logic [31:0] code_value;
  logic [7:0] profile_code;
  logic [1:0] chroma_format;
  logic [3:0] list_index;
  logic [6:0] coef_count;
  logic [7:0] last_scale, next_scale;
  logic [31:0] cycle_left, width_mbs, height_units;
  logic frame_only_flag;
  logic [31:0] crop_offsets [4];
  logic [7:0] cur_byte;
  logic [2:0] bit_idx;
  logic cur_last;
  logic started;
  // Size stage registers.
  logic [37:0] w_full, h_full, cw, ch;

  // Combinational working copies for one bit.
  phase_t n_phase;
  logic [5:0] n_zero_run, n_suffix_left;
  logic n_in_suffix;
  logic [31:0] n_code_value, n_cycle_left, n_width, n_height;
  logic [7:0] n_profile, n_last_scale, n_next_scale;
  logic [1:0] n_chroma;
  logic [3:0] n_list;
  logic [6:0] n_coef;
  logic n_frame_only;
  logic [31:0] n_crop [4];
  logic n_emit, n_size;
  logic [1:0] n_status;
  logic [31:0] fval, se_v;
  logic fdone, bitv;

  function automatic void do_start(input phase_t p, output phase_t ph,
                                   output logic [31:0] cv, output logic [5:0] zr,
                                   output logic isf, output logic [5:0] sl);
    ph = p;
    cv = '0;
    zr = '0;
    isf = (field_bits(p) != 4'd0);
    sl = {2'b00, field_bits(p)};
  endfunction

  assign bitv = cur_byte[bit_idx];

  always_comb begin
    logic [31:0] k;
    logic [4:0] lists;
    logic [6:0] size;
    logic scale_chk;
    n_phase = phase; n_zero_run = zero_run; n_suffix_left = suffix_left;
    n_in_suffix = in_suffix; n_code_value = code_value; n_cycle_left = cycle_left;
    n_width = width_mbs; n_height = height_units; n_profile = profile_code;
    n_last_scale = last_scale; n_next_scale = next_scale; n_chroma = chroma_format;
    n_list = list_index; n_coef = coef_count; n_frame_only = frame_only_flag;
    n_crop = crop_offsets; n_emit = 1'b0; n_size = 1'b0; n_status = ST_OK;
    fdone = 1'b0; fval = '0; scale_chk = 1'b0;
    k = '0; lists = '0; size = '0; se_v = '0;
    if (in_suffix) begin
      n_code_value = {code_value[30:0], bitv};
      n_suffix_left = suffix_left - 6'd1;
      if (n_suffix_left == '0) begin
        fdone = 1'b1;
        fval = ((32'd1 << zero_run) - 32'd1) + n_code_value;
      end
    end else if (bitv) begin
      if (zero_run == '0) begin
        fdone = 1'b1;
      end else begin
        n_in_suffix = 1'b1;
        n_suffix_left = zero_run;
        n_code_value = '0;
      end
    end else if (zero_run >= 6'(MAX_ZERO_RUN)) begin
      n_emit = 1'b1; n_status = ST_RANGE;
    end else begin
      n_zero_run = zero_run + 6'd1;
    end
    if (fdone) begin
      k = fval + 32'd1;
      se_v = k[0] ? (32'd0 - {1'b0, k[31:1]}) : {1'b0, k[31:1]};
      case (phase)
        PH_PROFILE: begin
          n_profile = fval[7:0];
          do_start(PH_CONSTR, n_phase, n_code_value, n_zero_run, n_in_suffix, n_suffix_left);
        end
        PH_CONSTR: do_start(PH_LEVEL, n_phase, n_code_value, n_zero_run, n_in_suffix,
                            n_suffix_left);
        PH_LEVEL: do_start(PH_SPSID, n_phase, n_code_value, n_zero_run, n_in_suffix,
                           n_suffix_left);
        PH_SPSID: do_start(is_high_profile(profile_code) ? PH_CHROMA : PH_LOG2FN,
                           n_phase, n_code_value, n_zero_run, n_in_suffix, n_suffix_left);
        PH_CHROMA: begin
          if (fval > 32'd3) begin
            n_emit = 1'b1; n_status = ST_RANGE;
          end else begin
            n_chroma = fval[1:0];
            do_start((fval == 32'd3) ? PH_SEPCOL : PH_DEPTHL, n_phase, n_code_value,
                     n_zero_run, n_in_suffix, n_suffix_left);
          end
        end
        PH_SEPCOL: do_start(PH_DEPTHL, n_phase, n_code_value, n_zero_run, n_in_suffix,
                            n_suffix_left);
        PH_DEPTHL: do_start(PH_DEPTHC, n_phase, n_code_value, n_zero_run, n_in_suffix,
                            n_suffix_left);
        PH_DEPTHC: do_start(PH_BYPASS, n_phase, n_code_value, n_zero_run, n_in_suffix,
                            n_suffix_left);
        PH_BYPASS: do_start(PH_MATRIX, n_phase, n_code_value, n_zero_run, n_in_suffix,
                            n_suffix_left);
        PH_MATRIX: begin
          n_list = '0;
          do_start((fval != 0) ? PH_LISTFLAG : PH_LOG2FN, n_phase, n_code_value,
                   n_zero_run, n_in_suffix, n_suffix_left);
        end
        PH_LISTFLAG: begin
          n_coef = '0;
          n_last_scale = 8'd8;
          n_next_scale = (fval != 0) ? 8'd8 : 8'd0;
          scale_chk = 1'b1;
        end
        PH_DELTA: begin
          n_next_scale = last_scale + se_v[7:0];
          if (n_next_scale != 0) n_last_scale = n_next_scale;
          n_coef = coef_count + 7'd1;
          scale_chk = 1'b1;
        end
        PH_LOG2FN: do_start(PH_POCTYPE, n_phase, n_code_value, n_zero_run, n_in_suffix,
                            n_suffix_left);
        PH_POCTYPE: do_start((fval == 0) ? PH_LOG2POC : (fval == 1) ? PH_ALWAYSZ
                             : PH_MAXREF, n_phase, n_code_value, n_zero_run,
                             n_in_suffix, n_suffix_left);
        PH_LOG2POC: do_start(PH_MAXREF, n_phase, n_code_value, n_zero_run, n_in_suffix,
                             n_suffix_left);
        PH_ALWAYSZ: do_start(PH_NONREF, n_phase, n_code_value, n_zero_run, n_in_suffix,
                             n_suffix_left);
        PH_NONREF: do_start(PH_TOPBOT, n_phase, n_code_value, n_zero_run, n_in_suffix,
                            n_suffix_left);
        PH_TOPBOT: do_start(PH_CYCLE, n_phase, n_code_value, n_zero_run, n_in_suffix,
                            n_suffix_left);
        PH_CYCLE: begin
          n_cycle_left = fval;
          do_start((fval != 0) ? PH_REFOFF : PH_MAXREF, n_phase, n_code_value,
                   n_zero_run, n_in_suffix, n_suffix_left);
        end
        PH_REFOFF: begin
          n_cycle_left = cycle_left - 32'd1;
          do_start((n_cycle_left != 0) ? PH_REFOFF : PH_MAXREF, n_phase, n_code_value,
                   n_zero_run, n_in_suffix, n_suffix_left);
        end
        PH_MAXREF: do_start(PH_GAPS, n_phase, n_code_value, n_zero_run, n_in_suffix,
                            n_suffix_left);
        PH_GAPS: do_start(PH_WIDTH, n_phase, n_code_value, n_zero_run, n_in_suffix,
                          n_suffix_left);
        PH_WIDTH: begin
          n_width = fval;
          do_start(PH_HEIGHT, n_phase, n_code_value, n_zero_run, n_in_suffix,
                   n_suffix_left);
        end
        PH_HEIGHT: begin
          n_height = fval;
          do_start(PH_FMO, n_phase, n_code_value, n_zero_run, n_in_suffix, n_suffix_left);
        end
        PH_FMO: begin
          n_frame_only = fval[0];
          do_start(fval[0] ? PH_D8X8 : PH_MBAFF, n_phase, n_code_value, n_zero_run,
                   n_in_suffix, n_suffix_left);
        end
        PH_MBAFF: do_start(PH_D8X8, n_phase, n_code_value, n_zero_run, n_in_suffix,
                           n_suffix_left);
        PH_D8X8: do_start(PH_CROPF, n_phase, n_code_value, n_zero_run, n_in_suffix,
                          n_suffix_left);
        PH_CROPF: begin
          if (fval != 0) begin
            n_list = '0;
            do_start(PH_CROP, n_phase, n_code_value, n_zero_run, n_in_suffix,
                     n_suffix_left);
          end else begin
            n_size = 1'b1;
          end
        end
        PH_CROP: begin
          n_crop[list_index[1:0]] = fval;
          n_list = list_index + 4'd1;
          if (n_list < 4'd4)
            do_start(PH_CROP, n_phase, n_code_value, n_zero_run, n_in_suffix,
                     n_suffix_left);
          else
            n_size = 1'b1;
        end
        default: begin
          n_emit = 1'b1; n_status = ST_RANGE;
        end
      endcase
      if (scale_chk) begin
        size = (list_index < 4'd6) ? 7'd16 : 7'd64;
        lists = (chroma_format == 2'd3) ? 5'd12 : 5'd8;
        if (n_coef < size && n_next_scale != 0) begin
          do_start(PH_DELTA, n_phase, n_code_value, n_zero_run, n_in_suffix,
                   n_suffix_left);
        end else begin
          n_list = list_index + 4'd1;
          do_start(({1'b0, n_list} < lists) ? PH_LISTFLAG : PH_LOG2FN, n_phase,
                   n_code_value, n_zero_run, n_in_suffix, n_suffix_left);
        end
      end
    end
  end

  logic fresh;
  logic [7:0] hdr_exp;
  assign fresh = q_data.first_byte || !started;

  always_comb begin
    case (fresh ? 3'd0 : header_count)
      3'd3: hdr_exp = 8'h01;
      3'd4: hdr_exp = 8'h67;
      default: hdr_exp = 8'h00;
    endcase
  end

  // A new byte is taken only when the result slot is free, so every byte can emit.
  always_comb begin
    be_next = be;
    q_pop = 1'b0;
    case (be)
      BE_IDLE: if (!q_empty && !res_valid) q_pop = 1'b1;
      BE_BITS, BE_SIZE1, BE_SIZE2: be_next = be;
      default: be_next = BE_IDLE;
    endcase
  end

  logic [37:0] d_w, d_h, lim;
  logic [1:0] ux, uy_c;
  assign lim = (38'd1 << DIM_BITS) - 38'd1;
  assign d_w = w_full - cw;
  assign d_h = h_full - ch;
  assign ux = (chroma_format == 2'd1 || chroma_format == 2'd2) ? 2'd2 : 2'd1;
  assign uy_c = (chroma_format == 2'd1) ? 2'd2 : 2'd1;

  function automatic out_item_t mk(input logic [15:0] w, input logic [15:0] h,
                                   input logic [1:0] s);
    out_item_t r;
    r.width_pixels = w;
    r.height_pixels = h;
    r.status = s;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      be <= BE_IDLE;
      phase <= PH_HDR;
      started <= 1'b0;
      res_valid <= 1'b0;
      header_count <= '0;
    end else begin
      if (res_valid && res_pop) res_valid <= 1'b0;
      case (be)
        BE_IDLE: begin
          if (q_pop) begin
            started <= 1'b1;
            cur_byte <= q_data.data_byte;
            cur_last <= q_data.last_byte;
            bit_idx <= 3'd7;
            if (fresh) begin
              zero_run <= '0; suffix_left <= '0; code_value <= '0; in_suffix <= 1'b0;
              profile_code <= '0; chroma_format <= 2'd1; list_index <= '0;
              coef_count <= '0; last_scale <= 8'd8; next_scale <= 8'd8;
              cycle_left <= '0; width_mbs <= '0; height_units <= '0;
              frame_only_flag <= 1'b0;
              for (int i = 0; i < 4; i++) crop_offsets[i] <= '0;
            end
            if (!fresh && phase == PH_DONE) begin
              // ignored
            end else if (fresh || phase == PH_HDR) begin
              if (!fresh && header_count >= 3'd5 || q_data.data_byte != hdr_exp) begin
                res_data <= mk('0, '0, ST_HEADER); res_valid <= 1'b1; phase <= PH_DONE;
                header_count <= fresh ? 3'd0 : header_count;
              end else begin
                header_count <= (fresh ? 3'd0 : header_count) + 3'd1;
                if ((fresh ? 3'd0 : header_count) == 3'd4) begin
                  phase <= PH_PROFILE; in_suffix <= 1'b1; suffix_left <= 6'd8;
                  code_value <= '0; zero_run <= '0;
                end else begin
                  phase <= PH_HDR;
                end
                if (q_data.last_byte && (fresh ? 3'd0 : header_count) != 3'd4) begin
                  res_data <= mk('0, '0, ST_TRUNC); res_valid <= 1'b1; phase <= PH_DONE;
                end else if (q_data.last_byte) begin
                  res_data <= mk('0, '0, ST_TRUNC); res_valid <= 1'b1; phase <= PH_DONE;
                end
              end
            end else begin
              be <= BE_BITS;
            end
          end
        end
        BE_BITS: begin
          phase <= n_phase; zero_run <= n_zero_run; suffix_left <= n_suffix_left;
          in_suffix <= n_in_suffix; code_value <= n_code_value; cycle_left <= n_cycle_left;
          width_mbs <= n_width; height_units <= n_height; profile_code <= n_profile;
          last_scale <= n_last_scale; next_scale <= n_next_scale; chroma_format <= n_chroma;
          list_index <= n_list; coef_count <= n_coef; frame_only_flag <= n_frame_only;
          crop_offsets <= n_crop;
          bit_idx <= bit_idx - 3'd1;
          if (n_emit) begin
            res_data <= mk('0, '0, n_status); res_valid <= 1'b1;
            phase <= PH_DONE; be <= BE_IDLE;
          end else if (n_size) begin
            phase <= PH_DONE; be <= BE_SIZE1;
          end else if (bit_idx == 3'd0) begin
            be <= BE_IDLE;
            if (cur_last) begin
              res_data <= mk('0, '0, ST_TRUNC); res_valid <= 1'b1; phase <= PH_DONE;
            end
          end
        end
        BE_SIZE1: begin
          w_full <= ({6'd0, width_mbs} + 38'd1) << 4;
          h_full <= (({6'd0, height_units} + 38'd1) << 4) << !frame_only_flag;
          cw <= ({6'd0, crop_offsets[0]} + {6'd0, crop_offsets[1]}) << (ux == 2'd2);
          ch <= (({6'd0, crop_offsets[2]} + {6'd0, crop_offsets[3]}) << (uy_c == 2'd2))
                << !frame_only_flag;
          be <= BE_SIZE2;
        end
        BE_SIZE2: begin
          be <= BE_IDLE;
          res_valid <= 1'b1;
          if (cw >= w_full || ch >= h_full || d_w > lim || d_h > lim)
            res_data <= mk('0, '0, ST_RANGE);
          else
            res_data <= mk(d_w[15:0], d_h[15:0], ST_OK);
        end
        default: be <= be_next;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/h264_sps_resolution_parser.sv
// Channel | Dir | Handshake   | Payload
// in      | in  | push / full | data_byte, first_byte, last_byte
// out     | out | pop / empty | width_pixels, height_pixels, status
// A byte waits in a four-entry queue; the engine takes one bit per cycle of a body byte
// and no new byte until it is through with the last; a header byte is checked whole.
// A result moves from the engine into the output register when that is empty or popped,
// and the engine takes no byte while its own result slot is still full.
// The queue fills while the engine works or while two results wait unread.
// Reset (rst, synchronous) empties the queue and restarts header search.
`default_nettype none
`include "h264_sps_resolution_parser_assert.svh"
module h264_sps_resolution_parser (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  output logic full,
  input  wire sps_pkg::in_item_t in_item,
  output logic empty,
  input  wire logic pop,
  output sps_pkg::out_item_t out_item
);
  import sps_pkg::*;

  in_item_t q_data;
  out_item_t eng_data;
  logic q_empty, q_pop, eng_valid, eng_pop, out_valid, err_sized;

  sps_queue u_queue (
    .clk(clk), .rst(rst), .wr_en(push), .wr_data(in_item), .full(full),
    .rd_en(q_pop), .rd_data(q_data), .empty(q_empty)
  );

  sps_engine u_engine (
    .clk(clk), .rst(rst), .q_data(q_data), .q_empty(q_empty), .q_pop(q_pop),
    .res_data(eng_data), .res_valid(eng_valid), .res_pop(eng_pop)
  );

  // The output register lets the engine go on with the next unit while a result waits.
  assign eng_pop = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eng_valid && eng_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_valid && eng_pop) out_item <= eng_data;
  end

  assign empty = !out_valid;
  assign err_sized = (out_item.status == ST_OK) ||
                     (out_item.width_pixels == 16'd0 && out_item.height_pixels == 16'd0);

  `SPS_ASSERT_IMPL(a_err_zero, clk, rst, !out_valid || err_sized, "error result with size")
  `SPS_ASSERT_NEXT(a_hold, clk, rst, out_valid && !pop, out_valid && $stable(out_item), "held")
  `SPS_ASSERT_IMPL(a_pop_q, clk, rst, !(q_pop && q_empty), "pop from empty queue")
endmodule
`default_nettype wire

FILE: tb/sv/tb_h264_sps_resolution_parser.sv
`timescale 1ns / 1ps
module tb_h264_sps_resolution_parser;
  import sps_pkg::*;

  logic clk;
  logic rst;
  logic push;
  logic full;
  in_item_t in_item;
  logic empty;
  logic pop;
  out_item_t out_item;

  h264_sps_resolution_parser dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item)
  );

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  in_item_t pending_bytes[$];
  out_item_t expected_sizes[$];
  bit unit_bits[$];
  int errors = 0;
  int total_items = 0;
  int accepted = 0;
  int idle_cycles = 0;
  bit stim_done = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Copy of the parser state used to predict results.
  phase_t pr_phase;
  int unsigned pr_hdr_cnt, pr_zeros, pr_left, pr_code, pr_profile, pr_chroma;
  int unsigned pr_list, pr_coef, pr_last_sc, pr_next_sc, pr_cycle;
  int unsigned pr_wmbs, pr_hunits, pr_frame_only;
  int unsigned pr_crop[4];
  bit pr_in_suffix, pr_res_valid;
  out_item_t pr_res;

  function automatic int unsigned width_of(phase_t p);
    case (p)
      PH_PROFILE, PH_CONSTR, PH_LEVEL: return 8;
      PH_SEPCOL, PH_BYPASS, PH_MATRIX, PH_LISTFLAG, PH_ALWAYSZ, PH_GAPS,
      PH_FMO, PH_MBAFF, PH_D8X8, PH_CROPF: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic bit high_profile(int unsigned p);
    return p inside {100, 110, 122, 244, 44, 83, 86, 118, 128, 138, 139, 134, 135};
  endfunction

  function automatic void clear_unit();
    pr_phase = PH_HDR;
    pr_hdr_cnt = 0; pr_zeros = 0; pr_left = 0; pr_code = 0; pr_in_suffix = 0;
    pr_profile = 0; pr_chroma = 1; pr_list = 0; pr_coef = 0;
    pr_last_sc = 8; pr_next_sc = 8; pr_cycle = 0; pr_wmbs = 0; pr_hunits = 0;
    pr_frame_only = 0;
    for (int i = 0; i < 4; i++) pr_crop[i] = 0;
  endfunction

  function automatic void emit(int unsigned w, int unsigned h, logic [1:0] st);
    pr_res_valid = 1;
    pr_res.width_pixels = w[15:0];
    pr_res.height_pixels = h[15:0];
    pr_res.status = st;
    pr_phase = PH_DONE;
  endfunction

  function automatic void enter(phase_t p);
    pr_phase = p;
    pr_code = 0;
    pr_zeros = 0;
    pr_left = width_of(p);
    pr_in_suffix = (pr_left != 0);
  endfunction

  function automatic void finish_sizes();
    longint unsigned fac, w, h, ux, uy, cw, ch, lim;
    fac = 2 - pr_frame_only;
    w = (longint'(pr_wmbs) + 1) * 16;
    h = (longint'(pr_hunits) + 1) * 16 * fac;
    ux = (pr_chroma == 1 || pr_chroma == 2) ? 2 : 1;
    uy = fac * ((pr_chroma == 1) ? 2 : 1);
    cw = (longint'(pr_crop[0]) + pr_crop[1]) * ux;
    ch = (longint'(pr_crop[2]) + pr_crop[3]) * uy;
    lim = (64'd1 << DIM_BITS) - 1;
    if (cw >= w || ch >= h || w - cw > lim || h - ch > lim) emit(0, 0, ST_RANGE);
    else emit(int'(w - cw), int'(h - ch), ST_OK);
  endfunction

  function automatic void next_scale_step();
    int unsigned size, lists;
    size = (pr_list < 6) ? 16 : 64;
    lists = (pr_chroma == 3) ? 12 : 8;
    if (pr_coef < size && pr_next_sc != 0) begin
      enter(PH_DELTA);
      return;
    end
    pr_list++;
    if (pr_list < lists) enter(PH_LISTFLAG);
    else enter(PH_LOG2FN);
  endfunction

  function automatic void field_done(int unsigned v);
    int unsigned k, sv;
    case (pr_phase)
      PH_PROFILE: begin pr_profile = v & 8'hFF; enter(PH_CONSTR); end
      PH_CONSTR: enter(PH_LEVEL);
      PH_LEVEL: enter(PH_SPSID);
      PH_SPSID: enter(high_profile(pr_profile) ? PH_CHROMA : PH_LOG2FN);
      PH_CHROMA: begin
        if (v > 3) emit(0, 0, ST_RANGE);
        else begin
          pr_chroma = v;
          enter(v == 3 ? PH_SEPCOL : PH_DEPTHL);
        end
      end
      PH_SEPCOL: enter(PH_DEPTHL);
      PH_DEPTHL: enter(PH_DEPTHC);
      PH_DEPTHC: enter(PH_BYPASS);
      PH_BYPASS: enter(PH_MATRIX);
      PH_MATRIX: begin pr_list = 0; enter(v != 0 ? PH_LISTFLAG : PH_LOG2FN); end
      PH_LISTFLAG: begin
        pr_coef = 0;
        pr_last_sc = 8;
        pr_next_sc = (v != 0) ? 8 : 0;
        next_scale_step();
      end
      PH_DELTA: begin
        k = v + 1;
        sv = k[0] ? (0 - (k >> 1)) : (k >> 1);
        pr_next_sc = (pr_last_sc + sv) & 8'hFF;
        if (pr_next_sc != 0) pr_last_sc = pr_next_sc;
        pr_coef++;
        next_scale_step();
      end
      PH_LOG2FN: enter(PH_POCTYPE);
      PH_POCTYPE: begin
        if (v == 0) enter(PH_LOG2POC);
        else if (v == 1) enter(PH_ALWAYSZ);
        else enter(PH_MAXREF);
      end
      PH_LOG2POC: enter(PH_MAXREF);
      PH_ALWAYSZ: enter(PH_NONREF);
      PH_NONREF: enter(PH_TOPBOT);
      PH_TOPBOT: enter(PH_CYCLE);
      PH_CYCLE: begin pr_cycle = v; enter(v != 0 ? PH_REFOFF : PH_MAXREF); end
      PH_REFOFF: begin pr_cycle--; enter(pr_cycle != 0 ? PH_REFOFF : PH_MAXREF); end
      PH_MAXREF: enter(PH_GAPS);
      PH_GAPS: enter(PH_WIDTH);
      PH_WIDTH: begin pr_wmbs = v; enter(PH_HEIGHT); end
      PH_HEIGHT: begin pr_hunits = v; enter(PH_FMO); end
      PH_FMO: begin
        pr_frame_only = v & 1;
        enter(pr_frame_only != 0 ? PH_D8X8 : PH_MBAFF);
      end
      PH_MBAFF: enter(PH_D8X8);
      PH_D8X8: enter(PH_CROPF);
      PH_CROPF: begin
        if (v != 0) begin pr_list = 0; enter(PH_CROP); end
        else finish_sizes();
      end
      PH_CROP: begin
        pr_crop[pr_list & 3] = v;
        pr_list++;
        if (pr_list < 4) enter(PH_CROP);
        else finish_sizes();
      end
      default: emit(0, 0, ST_RANGE);
    endcase
  endfunction

  function automatic void take_bit(bit b);
    if (pr_in_suffix) begin
      pr_code = (pr_code << 1) | b;
      pr_left--;
      if (pr_left == 0) field_done(((32'd1 << pr_zeros) - 1) + pr_code);
    end else if (b) begin
      if (pr_zeros == 0) field_done(0);
      else begin
        pr_in_suffix = 1;
        pr_left = pr_zeros;
        pr_code = 0;
      end
    end else if (pr_zeros >= MAX_ZERO_RUN) begin
      emit(0, 0, ST_RANGE);
    end else begin
      pr_zeros++;
    end
  endfunction

  // Works out the result, if any, that one accepted request causes.
  function automatic void predict_size(in_item_t it);
    logic [7:0] hdr [5] = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67};
    pr_res_valid = 0;
    if (it.first_byte) clear_unit();
    if (pr_phase == PH_DONE) return;
    if (pr_phase == PH_HDR) begin
      if (pr_hdr_cnt >= 5 || it.data_byte != hdr[pr_hdr_cnt]) emit(0, 0, ST_HEADER);
      else begin
        pr_hdr_cnt++;
        if (pr_hdr_cnt == 5) enter(PH_PROFILE);
      end
    end else begin
      for (int i = 7; i >= 0 && pr_phase != PH_DONE; i--) take_bit(it.data_byte[i]);
    end
    if (!pr_res_valid && it.last_byte && pr_phase != PH_DONE) emit(0, 0, ST_TRUNC);
    if (pr_res_valid) expected_sizes.push_back(pr_res);
  endfunction

  // Bitstream writer for building units.
  task automatic put_bits(longint unsigned v, int n);
    for (int i = n - 1; i >= 0; i--) unit_bits.push_back(v[i]);
  endtask

  task automatic put_ue(longint unsigned v);
    longint unsigned x;
    int n;
    x = v + 1;
    n = 0;
    while ((x >> n) != 0) n++;
    put_bits(0, n - 1);
    put_bits(x, n);
  endtask

  task automatic put_se(int s);
    put_ue(s > 0 ? 2 * s - 1 : -2 * s);
  endtask

  function automatic longint unsigned rand_ue();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32'hFFFF_FFFE;
      2: return $urandom;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  // kind: 0 well-formed, 1 bad header, 2 truncated, 3 long zero run
  task automatic build_unit(int kind, bit mark_first);
    int unsigned prof, chroma, lists, poc, nbytes, cut;
    logic [7:0] hdr [5] = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67};
    int unsigned profs [8] = '{66, 77, 88, 100, 110, 122, 244, 134};
    in_item_t it;
    unit_bits.delete();
    prof = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                       : profs[$urandom_range(0, 7)];
    put_bits(prof, 8);
    put_bits($urandom, 16);
    put_ue($urandom_range(0, 31));
    if (kind == 3) put_bits(0, $urandom_range(32, 40));
    chroma = 1;
    if (high_profile(prof)) begin
      chroma = ($urandom_range(0, 11) == 0) ? $urandom_range(4, 300) : $urandom_range(0, 3);
      put_ue(chroma);
      if (chroma == 3) put_bits($urandom, 1);
      put_ue($urandom_range(0, 6));
      put_ue($urandom_range(0, 6));
      put_bits($urandom, 1);
      if ($urandom_range(0, 3) == 0) begin
        put_bits(1, 1);
        lists = (chroma == 3) ? 12 : 8;
        for (int l = 0; l < lists; l++) begin
          if ($urandom_range(0, 2) == 0) begin
            put_bits(1, 1);
            for (int c = 0; c < ((l < 6) ? 16 : 64); c++) begin
              if ($urandom_range(0, 9) == 0) put_se($urandom_range(0, 255) - 128);
              else put_se($urandom_range(0, 4) - 2);
            end
          end else begin
            put_bits(0, 1);
          end
        end
      end else begin
        put_bits(0, 1);
      end
    end
    put_ue($urandom_range(0, 12));
    poc = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 50) : $urandom_range(0, 2);
    put_ue(poc);
    if (poc == 0) put_ue($urandom_range(0, 12));
    else if (poc == 1) begin
      put_bits($urandom, 1);
      put_se($urandom_range(0, 200) - 100);
      put_se($urandom_range(0, 200) - 100);
      put_ue($urandom_range(0, 3));
      for (int i = 0; i < 3; i++) put_se($urandom_range(0, 20) - 10);
    end
    put_ue($urandom_range(0, 16));
    put_bits($urandom, 1);
    if ($urandom_range(0, 9) == 0) put_ue(rand_ue()); else put_ue($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) put_ue(rand_ue()); else put_ue($urandom_range(0, 135));
    put_bits($urandom, 3);
    if ($urandom_range(0, 1) == 0) begin
      put_bits(1, 1);
      for (int i = 0; i < 4; i++) begin
        if ($urandom_range(0, 7) == 0) put_ue(rand_ue()); else put_ue($urandom_range(0, 8));
      end
    end else begin
      put_bits(0, 1);
    end
    // Trailing bits, byte alignment with random padding, then a few stray bytes.
    put_bits(1, 1);
    while (unit_bits.size() % 8 != 0) unit_bits.push_back($urandom_range(0, 1));
    put_bits($urandom, 8 * $urandom_range(0, 3));
    nbytes = 5 + unit_bits.size() / 8;
    cut = nbytes;
    if (kind == 2) cut = $urandom_range(1, nbytes - 1);
    for (int b = 0; b < cut; b++) begin
      if (b < 5) it.data_byte = hdr[b];
      else for (int i = 0; i < 8; i++) it.data_byte[7 - i] = unit_bits[(b - 5) * 8 + i];
      if (kind == 1 && b == $urandom_range(0, 4)) it.data_byte = $urandom;
      it.first_byte = (b == 0) && mark_first;
      it.last_byte = (b == cut - 1) && (kind == 2 || $urandom_range(0, 1) == 0);
      pending_bytes.push_back(it);
    end
  endtask

  task automatic add_noise(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.data_byte = $urandom;
      it.first_byte = ($urandom_range(0, 3) == 0);
      it.last_byte = ($urandom_range(0, 3) == 0);
      pending_bytes.push_back(it);
    end
  endtask

  initial begin
    in_item_t it;
    int kind;
    rst = 1;
    // The parser starts out waiting for a header, as after reset.
    clear_unit();
    pr_res_valid = 0;
    // Directed: a unit after reset without its first mark, then each error path.
    build_unit(0, 0);
    build_unit(1, 1);
    build_unit(2, 1);
    build_unit(3, 1);
    it = '{data_byte: 8'hFF, first_byte: 1'b1, last_byte: 1'b1};
    pending_bytes.push_back(it);
    it = '{data_byte: 8'h00, first_byte: 1'b0, last_byte: 1'b1};
    pending_bytes.push_back(it);
    while (pending_bytes.size() < 1750) begin
      kind = $urandom_range(0, 19);
      if (kind < 14) build_unit(0, 1);
      else if (kind < 16) build_unit(1, 1);
      else if (kind < 18) build_unit(2, 1);
      else if (kind < 19) build_unit(3, 1);
      else add_noise($urandom_range(1, 6));
    end
    total_items = pending_bytes.size();
    repeat (6) @(posedge clk);
    rst <= 0;
    wait (stim_done && expected_sizes.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_sizes.size() == 0) begin
      $display("tb_h264_sps_resolution_parser: done, clean");
    end else begin
      $display("tb_h264_sps_resolution_parser: done, errors");
    end
    $finish;
  end

  // Five phases: no idling, sender idle, receiver stalls, both, long hold-off.
  function automatic int load_phase();
    return (total_items == 0) ? 0 : (accepted * 5) / total_items;
  endfunction

  always @(posedge clk) begin
    bit taken, idle;
    int ph;
    if (rst) begin
      push <= 0;
      in_item <= '0;
    end else begin
      taken = push && !full;
      if (taken) begin
        predict_size(in_item);
        accepted++;
      end
      if (taken || !push) begin
        ph = load_phase();
        idle = (ph == 1) ? ($urandom_range(0, 99) < 45) :
               (ph == 3) ? ($urandom_range(0, 99) < 31) : 0;
        if (pending_bytes.size() != 0 && !idle) begin
          push <= 1;
          in_item <= pending_bytes.pop_front();
        end else begin
          push <= 0;
          if (pending_bytes.size() == 0) stim_done <= 1;
        end
      end
    end
  end

  int hold_left = 0;
  bit hold_used = 0;

  always @(posedge clk) begin
    out_item_t want;
    int ph;
    if (rst) begin
      pop <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_sizes.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, out_item);
          errors++;
        end else begin
          want = expected_sizes.pop_front();
          if (out_item.width_pixels != want.width_pixels) begin
            $display("%0t: width_pixels expected %0d actual %0d", $time,
                     want.width_pixels, out_item.width_pixels);
            errors++;
          end
          if (out_item.height_pixels != want.height_pixels) begin
            $display("%0t: height_pixels expected %0d actual %0d", $time,
                     want.height_pixels, out_item.height_pixels);
            errors++;
          end
          if (out_item.status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_item.status);
            errors++;
          end
        end
      end
      ph = load_phase();
      if (ph == 4 && !hold_used) begin
        hold_used = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 0;
      end else if (ph == 2) pop <= ($urandom_range(0, 99) >= 45);
      else if (ph == 3) pop <= ($urandom_range(0, 99) >= 31);
      else pop <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_h264_sps_resolution_parser: done, errors");
      $finish;
    end
  end

endmodule
